/* hw/rtl/prdc_pkg.sv */
`default_nettype none

package prdc_pkg;

    // Field and register widths
    localparam int VALUE_WIDTH = 24;   // signed pressure and rate fields
    localparam int FRAC_BITS   = 8;    // fraction bits of the fixed-point fields
    localparam int CFG_W       = 16;   // configuration registers, divider, frequency
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int REG_IDX_W   = 2;

    // Divider step: floor(span / 100) as (span * STEP_RECIP) >> STEP_SHIFT,
    // exact for every 16-bit span
    localparam int RECIP_W    = 17;
    localparam int STEP_RECIP = 83887;
    localparam int STEP_SHIFT = 23;
    localparam int STEP_W     = 10;    // largest step is 655

    // Rate thresholds: 10*|r| against 17*|g| and 7*|g|
    localparam int RATE_DEN     = 10;
    localparam int RATE_UP_NUM  = 17;
    localparam int RATE_DN_NUM  = 7;
    localparam int RATE_W       = VALUE_WIDTH + 5;

    // Shared multiplier and long-division widths
    localparam int OPA_W  = CFG_W + 1;
    localparam int OPB_W  = (VALUE_WIDTH + 1 > RECIP_W + 1) ? VALUE_WIDTH + 1 : RECIP_W + 1;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int NUM_W  = SUM_W + FRAC_BITS;
    localparam int DEN_W  = PROD_W - 1;
    localparam int QCNT_W = $clog2(NUM_W + 1);
    localparam int DIVN_W = CFG_W + 2;  // signed divider update

    // Register map
    localparam logic [REG_IDX_W-1:0] REG_FREQ_FLOOR   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FREQ_CEILING = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DIV_FLOOR    = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_DIV_CEILING  = 2'd3;

    localparam logic [CFG_W-1:0] FREQ_FLOOR_RST   = 16'd0;
    localparam logic [CFG_W-1:0] FREQ_CEILING_RST = 16'd10000;
    localparam logic [CFG_W-1:0] DIV_FLOOR_RST    = 16'd26;
    localparam logic [CFG_W-1:0] DIV_CEILING_RST  = 16'd2560;
    localparam logic [CFG_W-1:0] DIVIDER_RST      = CFG_W'(1 << FRAC_BITS);

    // Datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
    localparam logic [OP_W-1:0] OP_SPAN      = 4'd1;
    localparam logic [OP_W-1:0] OP_STEP      = 4'd2;
    localparam logic [OP_W-1:0] OP_MUL_P     = 4'd3;
    localparam logic [OP_W-1:0] OP_MUL_G     = 4'd4;
    localparam logic [OP_W-1:0] OP_MUL_DEN   = 4'd5;
    localparam logic [OP_W-1:0] OP_PREP      = 4'd6;
    localparam logic [OP_W-1:0] OP_DIV_START = 4'd7;
    localparam logic [OP_W-1:0] OP_RESULT    = 4'd8;

    // Result selection
    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_NORMAL    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GOAL_ZERO = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DIV_ZERO  = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] freq_floor;
        logic [CFG_W-1:0] freq_ceiling;
        logic [CFG_W-1:0] divider_floor;
        logic [CFG_W-1:0] divider_ceiling;
    } cfg_t;

    typedef struct packed {
        logic              load;
        logic [OP_W-1:0]   op;
        logic [MODE_W-1:0] mode;
    } cmd_t;

    typedef struct packed {
        logic goal_zero;
        logic div_zero;
        logic div_done;
    } stat_t;

endpackage

`default_nettype wire

/* hw/rtl/prdc_in_if.sv */
`default_nettype none

interface prdc_in_if import prdc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] pressure_now;
    logic [VALUE_WIDTH-1:0] pressure_goal;
    logic [VALUE_WIDTH-1:0] rate_now;
    logic [VALUE_WIDTH-1:0] rate_goal;

    modport source (
        output valid, pressure_now, pressure_goal, rate_now, rate_goal,
        input  ready
    );

    modport sink (
        input  valid, pressure_now, pressure_goal, rate_now, rate_goal,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/prdc_out_if.sv */
`default_nettype none

interface prdc_out_if import prdc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] drive_freq;
    logic [CFG_W-1:0] divider_now;

    modport source (
        output valid, drive_freq, divider_now,
        input  ready
    );

    modport sink (
        input  valid, drive_freq, divider_now,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/prdc_cfg.sv */
`default_nettype none

module prdc_cfg import prdc_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t                 cfg_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.freq_floor      <= FREQ_FLOOR_RST;
            cfg_reg.freq_ceiling    <= FREQ_CEILING_RST;
            cfg_reg.divider_floor   <= DIV_FLOOR_RST;
            cfg_reg.divider_ceiling <= DIV_CEILING_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_FREQ_FLOOR:   cfg_reg.freq_floor      <= pwdata[CFG_W-1:0];
                REG_FREQ_CEILING: cfg_reg.freq_ceiling    <= pwdata[CFG_W-1:0];
                REG_DIV_FLOOR:    cfg_reg.divider_floor   <= pwdata[CFG_W-1:0];
                REG_DIV_CEILING:  cfg_reg.divider_ceiling <= pwdata[CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_FREQ_FLOOR:   prdata = DATA_W'(cfg_reg.freq_floor);
            REG_FREQ_CEILING: prdata = DATA_W'(cfg_reg.freq_ceiling);
            REG_DIV_FLOOR:    prdata = DATA_W'(cfg_reg.divider_floor);
            REG_DIV_CEILING:  prdata = DATA_W'(cfg_reg.divider_ceiling);
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/prdc_div.sv */
`default_nettype none

module prdc_div import prdc_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] numer,
    input  wire logic [DEN_W-1:0] denom,
    output logic      [NUM_W-1:0] quot,
    output logic                  done
);

    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DEN_W:0]    shifted;
    logic [DEN_W+1:0]  diff;
    logic              ge;
    logic [DEN_W-1:0]  rem_next;

    // Restoring division, one quotient bit per cycle
    assign shifted  = {rem_reg, quo_reg[NUM_W-1]};
    assign diff     = {1'b0, shifted} - {2'b00, denom};
    assign ge       = !diff[DEN_W+1];
    assign rem_next = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];

    assign quot = quo_reg;
    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= QCNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == QCNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= numer;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/prdc_dp.sv */
`default_nettype none

module prdc_dp import prdc_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cmd_t                   cmd,
    output stat_t                       stat,
    input  wire cfg_t                   cfg,
    input  wire logic [VALUE_WIDTH-1:0] pressure_now,
    input  wire logic [VALUE_WIDTH-1:0] pressure_goal,
    input  wire logic [VALUE_WIDTH-1:0] rate_now,
    input  wire logic [VALUE_WIDTH-1:0] rate_goal,
    output logic      [CFG_W-1:0]       drive_freq,
    output logic      [CFG_W-1:0]       divider_now
);

    // Item registers
    logic [VALUE_WIDTH-1:0] p_now_reg;
    logic [VALUE_WIDTH-1:0] p_goal_reg;
    logic [VALUE_WIDTH-1:0] r_now_reg;
    logic [VALUE_WIDTH-1:0] r_goal_reg;

    logic [CFG_W-1:0]        divider_reg;
    logic                    rate_up_reg;
    logic                    rate_dn_reg;
    logic                    span_neg_reg;
    logic [VALUE_WIDTH-1:0]  g_mag_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic [NUM_W-1:0]        numer_reg;
    logic                    q_neg_reg;
    logic [CFG_W-1:0]        drive_freq_reg;
    logic [CFG_W-1:0]        divider_out_reg;

    logic signed [OPA_W-1:0]  mul_a;
    logic signed [OPB_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;

    logic [VALUE_WIDTH-1:0] r_mag;
    logic [VALUE_WIDTH-1:0] g_mag;
    logic [RATE_W-1:0]      rate_lhs;
    logic [RATE_W-1:0]      rate_up_rhs;
    logic [RATE_W-1:0]      rate_dn_rhs;
    logic [OPA_W-1:0]       span;
    logic [CFG_W-1:0]       span_mag;

    logic [STEP_W-1:0]        step_mag;
    logic signed [DIVN_W-1:0] step_s;
    logic signed [DIVN_W-1:0] d_base;
    logic signed [DIVN_W-1:0] d_raw;
    logic signed [DIVN_W-1:0] d_hi;
    logic signed [DIVN_W-1:0] d_lo;
    logic signed [DIVN_W-1:0] dc_ext;
    logic signed [DIVN_W-1:0] df_ext;

    logic [SUM_W-1:0] acc_mag;
    logic [NUM_W-1:0] quot;
    logic             div_done;
    logic [CFG_W-1:0] q_hi;
    logic [CFG_W-1:0] res_freq;

    function automatic logic signed [OPA_W-1:0] span_free_freq(
        input logic [CFG_W-1:0] hi,
        input logic [CFG_W-1:0] lo
    );
        span_free_freq = {1'b0, hi} - {1'b0, lo};
    endfunction

    prdc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.op == OP_DIV_START),
        .numer (numer_reg),
        .denom (prod_reg[DEN_W-1:0]),
        .quot  (quot),
        .done  (div_done)
    );

    assign stat.goal_zero = (p_goal_reg == '0);
    assign stat.div_zero  = (divider_reg == '0);
    assign stat.div_done  = div_done;

    // Rate magnitudes and comparison terms
    assign r_mag       = r_now_reg[VALUE_WIDTH-1] ? (~r_now_reg + 1'b1) : r_now_reg;
    assign g_mag       = r_goal_reg[VALUE_WIDTH-1] ? (~r_goal_reg + 1'b1) : r_goal_reg;
    assign rate_lhs    = RATE_W'(r_mag) * RATE_W'(RATE_DEN);
    assign rate_up_rhs = RATE_W'(g_mag) * RATE_W'(RATE_UP_NUM);
    assign rate_dn_rhs = RATE_W'(g_mag) * RATE_W'(RATE_DN_NUM);

    // Divider span, signed
    assign span     = {1'b0, cfg.divider_ceiling} - {1'b0, cfg.divider_floor};
    assign span_mag = span[OPA_W-1] ? (~span[CFG_W-1:0] + 1'b1) : span[CFG_W-1:0];

    // Shared multiplier
    always_comb
    begin
        case (cmd.op)
            OP_SPAN:
            begin
                mul_a = {1'b0, span_mag};
                mul_b = OPB_W'(STEP_RECIP);
            end
            OP_MUL_P:
            begin
                mul_a = span_free_freq(cfg.freq_ceiling, cfg.freq_floor);
                mul_b = {{(OPB_W-VALUE_WIDTH){p_now_reg[VALUE_WIDTH-1]}}, p_now_reg};
            end
            OP_MUL_G:
            begin
                mul_a = {1'b0, cfg.freq_floor};
                mul_b = {{(OPB_W-VALUE_WIDTH){p_goal_reg[VALUE_WIDTH-1]}}, p_goal_reg};
            end
            OP_MUL_DEN:
            begin
                mul_a = {1'b0, divider_reg};
                mul_b = {{(OPB_W-VALUE_WIDTH){1'b0}}, g_mag_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Divider update: step by the truncated one-percent span, then clamp
    assign step_mag = prod_reg[STEP_SHIFT +: STEP_W];
    assign step_s   = span_neg_reg ? -DIVN_W'(step_mag) : DIVN_W'(step_mag);
    assign d_base   = {2'b00, divider_reg};
    assign dc_ext   = {2'b00, cfg.divider_ceiling};
    assign df_ext   = {2'b00, cfg.divider_floor};

    always_comb
    begin
        if (rate_up_reg)
        begin
            d_raw = d_base + step_s;
        end
        else if (rate_dn_reg)
        begin
            d_raw = d_base - step_s;
        end
        else
        begin
            d_raw = d_base;
        end
        d_hi = (d_raw > dc_ext) ? dc_ext : d_raw;
        d_lo = (d_hi < df_ext) ? df_ext : d_hi;
    end

    assign acc_mag = acc_reg[SUM_W-1] ? (~acc_reg + 1'b1) : acc_reg;

    // Final frequency select and clamp; the floor wins when the limits cross
    always_comb
    begin
        if ((quot[NUM_W-1:CFG_W] != '0) || (quot[CFG_W-1:0] > cfg.freq_ceiling))
        begin
            q_hi = cfg.freq_ceiling;
        end
        else
        begin
            q_hi = quot[CFG_W-1:0];
        end

        case (cmd.mode)
            MODE_GOAL_ZERO:
            begin
                res_freq = cfg.freq_floor;
            end
            MODE_DIV_ZERO:
            begin
                res_freq = (cfg.freq_ceiling < cfg.freq_floor) ? cfg.freq_floor
                                                               : cfg.freq_ceiling;
            end
            default:
            begin
                if ((q_neg_reg && (quot != '0)) || (q_hi < cfg.freq_floor))
                begin
                    res_freq = cfg.freq_floor;
                end
                else
                begin
                    res_freq = q_hi;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divider_reg <= DIVIDER_RST;
        end
        else if (cmd.op == OP_STEP)
        begin
            divider_reg <= d_lo[CFG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            p_now_reg  <= pressure_now;
            p_goal_reg <= pressure_goal;
            r_now_reg  <= rate_now;
            r_goal_reg <= rate_goal;
        end

        case (cmd.op)
            OP_SPAN:
            begin
                prod_reg     <= mul_p;
                rate_up_reg  <= (rate_lhs > rate_up_rhs);
                rate_dn_reg  <= (rate_lhs < rate_dn_rhs);
                span_neg_reg <= span[OPA_W-1];
                g_mag_reg    <= p_goal_reg[VALUE_WIDTH-1] ? (~p_goal_reg + 1'b1) : p_goal_reg;
            end
            OP_MUL_P:
            begin
                prod_reg <= mul_p;
            end
            OP_MUL_G:
            begin
                prod_reg <= mul_p;
                acc_reg  <= {prod_reg[PROD_W-1], prod_reg};
            end
            OP_MUL_DEN:
            begin
                prod_reg <= mul_p;
                acc_reg  <= acc_reg + {prod_reg[PROD_W-1], prod_reg};
            end
            OP_PREP:
            begin
                numer_reg <= {acc_mag, {FRAC_BITS{1'b0}}};
                q_neg_reg <= acc_reg[SUM_W-1] ^ p_goal_reg[VALUE_WIDTH-1];
            end
            OP_RESULT:
            begin
                drive_freq_reg  <= res_freq;
                divider_out_reg <= divider_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign drive_freq  = drive_freq_reg;
    assign divider_now = divider_out_reg;

endmodule

`default_nettype wire

/* hw/rtl/prdc_ctrl.sv */
`default_nettype none

module prdc_ctrl import prdc_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  wire logic  out_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE      = 4'd0;
    localparam logic [ST_W-1:0] ST_CHECK     = 4'd1;
    localparam logic [ST_W-1:0] ST_STEP      = 4'd2;
    localparam logic [ST_W-1:0] ST_MUL_P     = 4'd3;
    localparam logic [ST_W-1:0] ST_MUL_G     = 4'd4;
    localparam logic [ST_W-1:0] ST_MUL_DEN   = 4'd5;
    localparam logic [ST_W-1:0] ST_PREP      = 4'd6;
    localparam logic [ST_W-1:0] ST_DIV_START = 4'd7;
    localparam logic [ST_W-1:0] ST_DIV_WAIT  = 4'd8;
    localparam logic [ST_W-1:0] ST_RESULT    = 4'd9;

    logic [ST_W-1:0]   state_reg;
    logic [ST_W-1:0]   state_next;
    logic [MODE_W-1:0] mode_reg;
    logic [MODE_W-1:0] mode_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.goal_zero)
                begin
                    mode_next  = MODE_GOAL_ZERO;
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.op     = OP_SPAN;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                cmd.op     = OP_STEP;
                state_next = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                cmd.op     = OP_MUL_P;
                state_next = ST_MUL_G;
            end
            ST_MUL_G:
            begin
                cmd.op     = OP_MUL_G;
                state_next = ST_MUL_DEN;
            end
            ST_MUL_DEN:
            begin
                cmd.op = OP_MUL_DEN;
                if (stat.div_zero)
                begin
                    mode_next  = MODE_DIV_ZERO;
                    state_next = ST_RESULT;
                end
                else
                begin
                    mode_next  = MODE_NORMAL;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.op     = OP_PREP;
                state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                cmd.op     = OP_DIV_START;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_RESULT;
                    cmd.mode       = mode_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_NORMAL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/pump_rate_divider_control.sv */
// Flow: a zero target goes straight to the result without a divider step; a zero
//   divider skips the long division, which makes one quotient bit per cycle.
// Items: one at a time; the next input transfer is taken in the cycle
//   the result turns valid, while that result waits in the output register.
// Reset: rst_n is asynchronous, active low; it restores the register defaults and
//   sets the stored divider to 1.0. No clearing pass is needed.
`default_nettype none

module pump_rate_divider_control import prdc_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    prdc_in_if.sink                sample,
    prdc_out_if.source             result
);

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    // Configuration registers; the user must write them only between items (not enforced here)
    prdc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer: walks one item through rate compare and span multiply, divider step,
    // three more multiplies on the shared multiplier, and the long division
    prdc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: item registers, stored divider, multiplier, divider unit
    // and the output register
    prdc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg           (cfg),
        .pressure_now  (sample.pressure_now),
        .pressure_goal (sample.pressure_goal),
        .rate_now      (sample.rate_now),
        .rate_goal     (sample.rate_goal),
        .drive_freq    (result.drive_freq),
        .divider_now   (result.divider_now)
    );

    // One item at a time: ready drops right after an input transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> !sample.ready)
        else $error("input taken while an item is in flight");

    // A pending frequency never leaves the configured limits (floor wins on crossing)
    a_freq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ((result.drive_freq >= cfg.freq_floor) &&
                          ((result.drive_freq <= cfg.freq_floor) ||
                           (result.drive_freq <= cfg.freq_ceiling))))
        else $error("drive frequency outside the limits");

    // A new result appears only from the busy side of the sequencer
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(!sample.ready))
        else $error("result raised while idle");

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import prdc_pkg::*;

    // Run shape
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int SETTLE_CYCLES   = 80;      // longer than one item takes through the block
    localparam int HOLD_AT         = 200;     // results seen before the long hold-off
    localparam int HOLD_CYCLES     = 600;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int MAX_REPORTS     = 40;
    localparam int PLAN_LEN        = 25;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] pressure_now;
        logic [VALUE_WIDTH-1:0] pressure_goal;
        logic [VALUE_WIDTH-1:0] rate_now;
        logic [VALUE_WIDTH-1:0] rate_goal;
    } sample_t;

    typedef struct packed {
        logic [CFG_W-1:0] drive_freq;
        logic [CFG_W-1:0] divider_now;
    } result_t;

    // A directed row either sends one sample or reprograms the four limits
    // (floor/ceiling of frequency, then floor/ceiling of divider, in f0..f3).
    typedef enum logic {ROW_SAMPLE, ROW_LIMITS} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [VALUE_WIDTH-1:0] f0;
        logic [VALUE_WIDTH-1:0] f1;
        logic [VALUE_WIDTH-1:0] f2;
        logic [VALUE_WIDTH-1:0] f3;
        logic                   typed;
        logic [CFG_W-1:0]       want_freq;
        logic [CFG_W-1:0]       want_div;
    } plan_row_t;

    // Sample rows: pressure_now, pressure_goal, rate_now, rate_goal.
    // Typed rows carry a result that is plain from the arithmetic; the rest
    // go through the predictor.
    plan_row_t plan [PLAN_LEN] = '{
        // zero target: floor frequency, divider untouched
        '{ROW_SAMPLE, 24'd1234,   24'd0,      24'd5,      24'd5,      1'b1, 16'd0,     16'd256},
        // at target, no rate error: ceiling frequency
        '{ROW_SAMPLE, 24'd256,    24'd256,    24'd0,      24'd0,      1'b1, 16'd10000, 16'd256},
        '{ROW_SAMPLE, 24'd0,      24'd256,    24'd0,      24'd0,      1'b1, 16'd0,     16'd256},
        // twice the target: clamp at ceiling
        '{ROW_SAMPLE, 24'd512,    24'd256,    24'd0,      24'd0,      1'b1, 16'd10000, 16'd256},
        // negative pressure: clamp at floor
        '{ROW_SAMPLE, 24'hFFFF00, 24'd256,    24'd0,      24'd0,      1'b1, 16'd0,     16'd256},
        // rate exactly at 1.7x and at 0.7x: no step
        '{ROW_SAMPLE, 24'd128,    24'd256,    24'd17,     24'd10,     1'b1, 16'd5000,  16'd256},
        '{ROW_SAMPLE, 24'd128,    24'd256,    24'hFFFFF9, 24'd10,     1'b1, 16'd5000,  16'd256},
        // just over 1.7x with negative goal rate, then just under 0.7x
        '{ROW_SAMPLE, 24'd128,    24'd256,    24'd18,     24'hFFFFF6, 1'b0, 16'd0,     16'd0},
        '{ROW_SAMPLE, 24'd128,    24'd256,    24'd6,      24'd10,     1'b0, 16'd0,     16'd0},
        // field extremes
        '{ROW_SAMPLE, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, 1'b0, 16'd0,     16'd0},
        '{ROW_SAMPLE, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'd0,      1'b0, 16'd0,     16'd0},
        '{ROW_SAMPLE, 24'h800000, 24'h800000, 24'd0,      24'h800000, 1'b0, 16'd0,     16'd0},
        '{ROW_SAMPLE, 24'hFFFF00, 24'hFFFFFF, 24'd1,      24'd0,      1'b0, 16'd0,     16'd0},
        // widest span: step of 655
        '{ROW_LIMITS, 24'd0,      24'd65535,  24'd1,      24'd65535,  1'b0, 16'd0,     16'd0},
        '{ROW_SAMPLE, 24'h7FFFFF, 24'd1,      24'h7FFFFF, 24'd0,      1'b0, 16'd0,     16'd0},
        // divider limits crossed, negative span: floor wins
        '{ROW_LIMITS, 24'd0,      24'd10000,  24'd3000,   24'd1000,   1'b0, 16'd0,     16'd0},
        '{ROW_SAMPLE, 24'd256,    24'd256,    24'd0,      24'd0,      1'b1, 16'd853,   16'd3000},
        '{ROW_SAMPLE, 24'd77,     24'd256,    24'd100,    24'd1,      1'b0, 16'd0,     16'd0},
        // frequency limits crossed: floor wins
        '{ROW_LIMITS, 24'd5000,   24'd1000,   24'd3000,   24'd1000,   1'b0, 16'd0,     16'd0},
        '{ROW_SAMPLE, 24'd256,    24'd256,    24'd0,      24'd0,      1'b1, 16'd5000,  16'd3000},
        // zero divider, with crossed and then open frequency limits
        '{ROW_LIMITS, 24'd5000,   24'd1000,   24'd0,      24'd0,      1'b0, 16'd0,     16'd0},
        '{ROW_SAMPLE, 24'd256,    24'd256,    24'd0,      24'd0,      1'b1, 16'd5000,  16'd0},
        '{ROW_LIMITS, 24'd0,      24'd65535,  24'd0,      24'd0,      1'b0, 16'd0,     16'd0},
        '{ROW_SAMPLE, 24'd100,    24'hFFFED4, 24'd5,      24'd1,      1'b1, 16'd65535, 16'd0},
        '{ROW_SAMPLE, 24'd9,      24'd0,      24'd3,      24'd4,      1'b1, 16'd0,     16'd0}
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    prdc_in_if  sample_if ();
    prdc_out_if result_if ();

    pump_rate_divider_control i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (sample_if),
        .result  (result_if)
    );

    // Predictor state: register copy and the stored divider
    cfg_t             limits        = '{FREQ_FLOOR_RST, FREQ_CEILING_RST,
                                        DIV_FLOOR_RST, DIV_CEILING_RST};
    logic [CFG_W-1:0] divider_model = DIVIDER_RST;

    result_t expected_drive_q [$];
    int      mismatch_count = 0;
    int      cycle_count    = 0;
    bit      idling_on      = 1'b1;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case a transfer never completes
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Clamp with the lower limit winning when the limits cross
    function automatic longint clamp_low_wins(input longint lo, input longint v,
                                              input longint hi);
        if (v > hi)
            v = hi;
        if (v < lo)
            v = lo;
        return v;
    endfunction

    // Advance the divider for one sample and work out the drive frequency
    function automatic result_t predict_drive(input sample_t s);
        longint  p_now;
        longint  p_goal;
        longint  r_abs;
        longint  g_abs;
        longint  ff;
        longint  fc;
        longint  step_q;
        longint  div_next;
        longint  num;
        longint  den;
        longint  freq;
        result_t r;

        p_now  = longint'($signed(s.pressure_now));
        p_goal = longint'($signed(s.pressure_goal));
        ff     = longint'(limits.freq_floor);
        fc     = longint'(limits.freq_ceiling);

        // Zero target: floor frequency, divider neither stepped nor clamped
        if (p_goal == 0)
        begin
            r.drive_freq  = limits.freq_floor;
            r.divider_now = divider_model;
            return r;
        end

        r_abs = longint'($signed(s.rate_now));
        g_abs = longint'($signed(s.rate_goal));
        if (r_abs < 0)
            r_abs = -r_abs;
        if (g_abs < 0)
            g_abs = -g_abs;

        // Step is 1% of the span, toward zero; a negative span reverses it
        step_q   = (longint'(limits.divider_ceiling) - longint'(limits.divider_floor)) / 100;
        div_next = longint'(divider_model);
        if (10 * r_abs > 17 * g_abs)
            div_next += step_q;
        else if (10 * r_abs < 7 * g_abs)
            div_next -= step_q;
        divider_model = CFG_W'(clamp_low_wins(longint'(limits.divider_floor), div_next,
                                              longint'(limits.divider_ceiling)));

        if (divider_model == '0)
        begin
            // Quotient counts as above every limit
            freq = clamp_low_wins(ff, fc, fc);
        end
        else
        begin
            num = ((fc - ff) * p_now + ff * p_goal) * (longint'(1) << FRAC_BITS);
            den = p_goal * longint'(divider_model);
            if (den < 0)
            begin
                den = -den;
                num = -num;
            end
            freq = clamp_low_wins(ff, num / den, fc);
        end

        r.drive_freq  = CFG_W'(freq);
        r.divider_now = divider_model;
        return r;
    endfunction

    // Random signed level with a random magnitude width
    function automatic logic [VALUE_WIDTH-1:0] rand_level();
        int                     w;
        logic [VALUE_WIDTH-1:0] v;

        w = $urandom_range(0, VALUE_WIDTH - 1);
        v = VALUE_WIDTH'($urandom) & ((VALUE_WIDTH'(1) << w) - 1'b1);
        if ($urandom_range(0, 1) == 1)
            v = -v;
        return v;
    endfunction

    task automatic flag_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t %s: expected %0d actual %0d", $time, what, want, got);
    endtask

    // One APB write, then read the register back through the same port
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= DATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        // go straight into the setup phase of the read
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[CFG_W-1:0] !== val)
            flag_mismatch("register read-back", val, prdata[CFG_W-1:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_limits(input cfg_t c);
        write_reg(REG_FREQ_FLOOR,   c.freq_floor);
        write_reg(REG_FREQ_CEILING, c.freq_ceiling);
        write_reg(REG_DIV_FLOOR,    c.divider_floor);
        write_reg(REG_DIV_CEILING,  c.divider_ceiling);
        limits = c;
    endtask

    // Drop valid, wait out every pending result and the pipeline tail
    task automatic settle();
        sample_if.valid <= 1'b0;
        while (expected_drive_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offer one sample; record its expected result at the transfer edge.
    // Valid stays high into the next call unless a gap lowers it first.
    task automatic send_sample(input sample_t s, input logic typed, input result_t typed_res);
        result_t predicted;

        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            sample_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        sample_if.valid         <= 1'b1;
        sample_if.pressure_now  <= s.pressure_now;
        sample_if.pressure_goal <= s.pressure_goal;
        sample_if.rate_now      <= s.rate_now;
        sample_if.rate_goal     <= s.rate_goal;
        do @(posedge clk); while (!sample_if.ready);

        // Advance the predictor even where the row spells out its result
        predicted = predict_drive(s);
        expected_drive_q.push_back(typed ? typed_res : predicted);
    endtask

    // Result side: check each transfer against the oldest expectation,
    // stall in random bursts, and hold off once for a long stretch so the
    // block fills and pushes back on the sample side.
    initial
    begin : result_side
        int      stall_left;
        int      results_seen;
        bit      held;
        result_t got;
        result_t want;

        stall_left   = 0;
        results_seen = 0;
        held         = 1'b0;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_if.valid && result_if.ready)
            begin
                got.drive_freq  = result_if.drive_freq;
                got.divider_now = result_if.divider_now;
                results_seen++;
                if (expected_drive_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t unexpected result: expected none actual %0d/%0d",
                                 $time, got.drive_freq, got.divider_now);
                end
                else
                begin
                    want = expected_drive_q.pop_front();
                    if (got.drive_freq !== want.drive_freq)
                        flag_mismatch("drive_freq", want.drive_freq, got.drive_freq);
                    if (got.divider_now !== want.divider_now)
                        flag_mismatch("divider_now", want.divider_now, got.divider_now);
                end
            end

            if (!held && results_seen >= HOLD_AT)
            begin
                held       = 1'b1;
                stall_left = HOLD_CYCLES;
            end

            if (stall_left > 0)
            begin
                stall_left--;
                result_if.ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                result_if.ready <= 1'b0;
            end
            else
            begin
                result_if.ready <= 1'b1;
            end
        end
    end

    // Sample side and register programming
    initial
    begin : sample_side
        sample_t s;
        result_t typed_res;
        cfg_t    new_limits;
        int      mix;
        int      k;
        longint  goal_l;
        longint  rate_l;

        // Hold every input at a known value through reset
        rst_n                   <= 1'b0;
        psel                    <= 1'b0;
        penable                 <= 1'b0;
        pwrite                  <= 1'b0;
        paddr                   <= '0;
        pwdata                  <= '0;
        sample_if.valid         <= 1'b0;
        sample_if.pressure_now  <= '0;
        sample_if.pressure_goal <= '0;
        sample_if.rate_now      <= '0;
        sample_if.rate_goal     <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (plan[i].kind == ROW_LIMITS)
            begin
                settle();
                new_limits.freq_floor      = plan[i].f0[CFG_W-1:0];
                new_limits.freq_ceiling    = plan[i].f1[CFG_W-1:0];
                new_limits.divider_floor   = plan[i].f2[CFG_W-1:0];
                new_limits.divider_ceiling = plan[i].f3[CFG_W-1:0];
                program_limits(new_limits);
            end
            else
            begin
                s.pressure_now        = plan[i].f0;
                s.pressure_goal       = plan[i].f1;
                s.rate_now            = plan[i].f2;
                s.rate_goal           = plan[i].f3;
                typed_res.drive_freq  = plan[i].want_freq;
                typed_res.divider_now = plan[i].want_div;
                send_sample(s, plan[i].typed, typed_res);
            end
        end

        // Random phases, each under its own limits
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: new_limits = '{FREQ_FLOOR_RST, FREQ_CEILING_RST,
                                  DIV_FLOOR_RST, DIV_CEILING_RST};
                1: new_limits = '{16'd0, 16'hFFFF, 16'd1, 16'hFFFF};
                2: new_limits = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                3: new_limits = '{16'd0, 16'd0, 16'd1, 16'd1};
                default:
                begin
                    new_limits.freq_floor      = CFG_W'($urandom_range(0, 4000));
                    new_limits.freq_ceiling    = CFG_W'($urandom_range(4000, 65535));
                    new_limits.divider_floor   = CFG_W'($urandom_range(0, 300));
                    new_limits.divider_ceiling = CFG_W'($urandom_range(300, 8000));
                    // cross the limits now and then
                    if ($urandom_range(0, 4) == 0)
                        {new_limits.freq_floor, new_limits.freq_ceiling} =
                            {new_limits.freq_ceiling, new_limits.freq_floor};
                    if ($urandom_range(0, 4) == 0)
                        {new_limits.divider_floor, new_limits.divider_ceiling} =
                            {new_limits.divider_ceiling, new_limits.divider_floor};
                end
            endcase
            settle();
            program_limits(new_limits);
            // leave some phases and the closing one free of idling
            idling_on = (ph % 4 != 3) && (ph != RANDOM_PHASES - 1);

            repeat (ITEMS_PER_PHASE)
            begin
                mix = $urandom_range(0, 99);
                if (mix < 15)
                begin
                    // raw noise over every bit
                    s = {$urandom, $urandom, $urandom};
                end
                else
                begin
                    // pressure as a fraction of the target, rate near the bands
                    s.pressure_goal = rand_level();
                    s.rate_goal     = rand_level();
                    goal_l          = longint'($signed(s.pressure_goal));
                    k               = $urandom_range(0, 1200);
                    goal_l          = goal_l * k / 1000;
                    if (mix < 22)
                        goal_l = -goal_l;
                    s.pressure_now = VALUE_WIDTH'(goal_l);

                    rate_l = longint'($signed(s.rate_goal));
                    case ($urandom_range(0, 4))
                        0: k = $urandom_range(18, 60);
                        1: k = $urandom_range(0, 6);
                        2: k = $urandom_range(7, 17);
                        3: k = 17;
                        default: k = 7;
                    endcase
                    rate_l = rate_l * k / 10;
                    if (k == 17 || k == 7)
                    begin
                        // straddle the band edges by one
                        k      = $urandom_range(0, 2);
                        rate_l = rate_l + k - 1;
                    end
                    if ($urandom_range(0, 1) == 1)
                        rate_l = -rate_l;
                    s.rate_now = VALUE_WIDTH'(rate_l);
                end
                if (mix >= 95)
                    s.pressure_goal = '0;
                send_sample(s, 1'b0, '0);
            end
        end

        // Drain, then allow for anything stray
        settle();
        if (mismatch_count == 0 && expected_drive_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/prdc_pkg.sv
hw/rtl/prdc_in_if.sv
hw/rtl/prdc_out_if.sv
hw/rtl/prdc_cfg.sv
hw/rtl/prdc_div.sv
hw/rtl/prdc_dp.sv
hw/rtl/prdc_ctrl.sv
hw/rtl/pump_rate_divider_control.sv
tb/sv/tb_top.sv
